// ----- hw/rtl/matrix3x3_inverse_unit_assert.svh -----
// Assertion macros used by the matrix inverse unit.
`ifndef MATRIX3X3_INVERSE_UNIT_ASSERT_SVH
`define MATRIX3X3_INVERSE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define M3I_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("m3i assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define M3I_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("m3i assertion failed");

`endif

// ----- hw/rtl/m3i_pkg.sv -----
// Types and constants for the 3x3 matrix inverse unit.
package m3i_pkg;

   // Fixed widths and stage counts of the arithmetic.
   localparam int ELEM_W    = 32;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int ADJ_W     = PROD_W + 1;
   localparam int TERM_W    = ELEM_W + ADJ_W;
   localparam int DET_W     = TERM_W + 2;
   localparam int QUO_W     = 32;
   localparam int FRONT_LAT = 5;
   localparam int DIV_LAT   = QUO_W + 4;

   localparam logic [QUO_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [QUO_W-1:0] SAT_MIN = 32'h8000_0000;

   typedef logic [3:0] idx_type;

   // Operands p, q, r, s of each adjugate element p*q - r*s, as flat indices r*3+c.
   localparam idx_type MINOR_IDX [9][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7},
      '{4'd2, 4'd7, 4'd1, 4'd8},
      '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8},
      '{4'd0, 4'd8, 4'd2, 4'd6},
      '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6},
      '{4'd1, 4'd6, 4'd0, 4'd7},
      '{4'd0, 4'd4, 4'd1, 4'd3}
   };

   typedef struct packed {
      logic signed [31:0] in_r0c0;
      logic signed [31:0] in_r0c1;
      logic signed [31:0] in_r0c2;
      logic signed [31:0] in_r1c0;
      logic signed [31:0] in_r1c1;
      logic signed [31:0] in_r1c2;
      logic signed [31:0] in_r2c0;
      logic signed [31:0] in_r2c1;
      logic signed [31:0] in_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_r0c0;
      logic signed [31:0] out_r0c1;
      logic signed [31:0] out_r0c2;
      logic signed [31:0] out_r1c0;
      logic signed [31:0] out_r1c1;
      logic signed [31:0] out_r1c2;
      logic signed [31:0] out_r2c0;
      logic signed [31:0] out_r2c1;
      logic signed [31:0] out_r2c2;
      logic               singular;
   } rsp_type;

endpackage

// ----- hw/rtl/m3i_if.sv -----
// Valid/ready channel interfaces for matrix requests and inverse responses.
interface m3i_req_if;
   logic              valid;
   logic              ready;
   m3i_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface m3i_rsp_if;
   logic              valid;
   logic              ready;
   m3i_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/m3i_div.sv -----
// Pipelined signed divider: one quotient bit per stage, rounded and saturated to 32 bits.
module m3i_div #(
   parameter int NUM_W = 97,
   parameter int DEN_W = 99
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [NUM_W-1:0]  num_in,
   input  logic signed [DEN_W-1:0]  den_in,
   output logic [m3i_pkg::QUO_W-1:0] q_out
);
   localparam int QB = m3i_pkg::QUO_W;
   localparam int RW = DEN_W + QB;

   logic [NUM_W-1:0] num_mag_ff;
   logic [DEN_W-1:0] den_mag_ff;
   logic             neg_a_ff;

   logic [RW-1:0]    rem_ff [0:QB];
   logic [QB-1:0]    q_ff   [0:QB];
   logic [DEN_W-1:0] den_ff [0:QB];
   logic             neg_ff [0:QB];
   logic             ovf_ff [0:QB];

   logic [QB:0]      qr_ff;
   logic             neg_r_ff;
   logic             ovf_r_ff;
   logic [QB-1:0]    q_out_ff;

   logic [RW:0]      twice_in;
   logic [QB:0]      qr_in;
   logic [QB-1:0]    sat_in;

   // Magnitudes and the sign of the quotient.
   always_ff @(posedge clock) begin
      if (en) begin
         num_mag_ff <= num_in[NUM_W-1] ? NUM_W'(-num_in) : NUM_W'(num_in);
         den_mag_ff <= den_in[DEN_W-1] ? DEN_W'(-den_in) : DEN_W'(den_in);
         neg_a_ff   <= num_in[NUM_W-1] ^ den_in[DEN_W-1];
      end
   end

   // A quotient of 2^32 or more saturates regardless of the bits below.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(num_mag_ff);
         q_ff[0]   <= '0;
         den_ff[0] <= den_mag_ff;
         neg_ff[0] <= neg_a_ff;
         ovf_ff[0] <= RW'(num_mag_ff) >= {den_mag_ff, {QB{1'b0}}};
      end
   end

   // Restoring division, most significant quotient bit first.
   for (genvar j = 0; j < QB; j++) begin : g_bit
      localparam int BIT = QB - 1 - j;
      logic [RW-1:0] sh_in;
      logic          ge_in;
      logic [QB-1:0] q_in;

      always_comb begin
         sh_in    = RW'(den_ff[j]) << BIT;
         ge_in    = rem_ff[j] >= sh_in;
         q_in     = q_ff[j];
         q_in[BIT] = ge_in;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= ge_in ? rem_ff[j] - sh_in : rem_ff[j];
            q_ff[j+1]   <= q_in;
            den_ff[j+1] <= den_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
         end
      end
   end

   // Round half away from zero on the magnitude.
   always_comb begin
      twice_in = {rem_ff[QB], 1'b0};
      qr_in    = {1'b0, q_ff[QB]} + (QB+1)'(twice_in >= (RW+1)'(den_ff[QB]));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qr_ff    <= qr_in;
         neg_r_ff <= neg_ff[QB];
         ovf_r_ff <= ovf_ff[QB];
      end
   end

   // Apply the sign and clamp to the signed 32-bit range.
   always_comb begin
      if (ovf_r_ff) begin
         sat_in = neg_r_ff ? m3i_pkg::SAT_MIN : m3i_pkg::SAT_MAX;
      end else if (neg_r_ff) begin
         sat_in = (qr_ff >= {1'b0, m3i_pkg::SAT_MIN}) ? m3i_pkg::SAT_MIN : QB'(-qr_ff);
      end else begin
         sat_in = (qr_ff > {1'b0, m3i_pkg::SAT_MAX}) ? m3i_pkg::SAT_MAX : qr_ff[QB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_out_ff <= sat_in;
      end
   end

   assign q_out = q_out_ff;

endmodule

// ----- hw/rtl/matrix3x3_inverse_unit.sv -----
// Throughput: one matrix per cycle unless the output stalls; five multiply/add
// stages feed nine dividers that resolve one quotient bit per stage.
// The whole pipeline holds while a finished response waits to be taken.
// Synchronous active-high reset clears the stage valid bits only.
`include "matrix3x3_inverse_unit_assert.svh"

module matrix3x3_inverse_unit #(
   parameter int FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   m3i_req_if.sink    req_chan,
   m3i_rsp_if.source  rsp_chan
);
   localparam int ELEM_W  = m3i_pkg::ELEM_W;
   localparam int PROD_W  = m3i_pkg::PROD_W;
   localparam int ADJ_W   = m3i_pkg::ADJ_W;
   localparam int TERM_W  = m3i_pkg::TERM_W;
   localparam int DET_W   = m3i_pkg::DET_W;
   localparam int DIV_LAT = m3i_pkg::DIV_LAT;
   localparam int NUM_W   = ADJ_W + 2 * FRAC_BITS;
   localparam int NSTG    = m3i_pkg::FRONT_LAT + DIV_LAT + 1;
   localparam logic [ELEM_W-1:0] ONE = ELEM_W'(1) << FRAC_BITS;

   logic                     en;
   logic                     valid_ff [NSTG];
   logic signed [ELEM_W-1:0] a_in [9];

   logic signed [PROD_W-1:0] prod_ff [18];
   logic signed [ELEM_W-1:0] a1_ff [3];
   logic signed [ELEM_W-1:0] a2_ff [3];
   logic signed [ADJ_W-1:0]  adj2_ff [9];
   logic signed [ADJ_W-1:0]  adj3_ff [9];
   logic signed [ADJ_W-1:0]  adj4_ff [9];
   logic signed [ADJ_W-1:0]  adj5_ff [9];
   logic signed [ADJ_W-1:0]  plo_ff [3];
   logic signed [ADJ_W-1:0]  phi_ff [3];
   logic signed [TERM_W-1:0] term_ff [3];
   logic signed [DET_W-1:0]  det_ff;
   logic                     sing_ff [DIV_LAT];
   logic [ELEM_W-1:0]        q_res [9];
   logic [ELEM_W-1:0]        res_in [9];
   m3i_pkg::rsp_type         out_ff;
   logic                     sing_ident;

   // The pipeline advances unless the output holds an untaken result.
   assign en             = !valid_ff[NSTG-1] || rsp_chan.ready;
   assign req_chan.ready = en;
   assign rsp_chan.valid = valid_ff[NSTG-1];
   assign rsp_chan.data  = out_ff;

   assign a_in[0] = req_chan.data.in_r0c0;
   assign a_in[1] = req_chan.data.in_r0c1;
   assign a_in[2] = req_chan.data.in_r0c2;
   assign a_in[3] = req_chan.data.in_r1c0;
   assign a_in[4] = req_chan.data.in_r1c1;
   assign a_in[5] = req_chan.data.in_r1c2;
   assign a_in[6] = req_chan.data.in_r2c0;
   assign a_in[7] = req_chan.data.in_r2c1;
   assign a_in[8] = req_chan.data.in_r2c2;

   // Stage valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NSTG; k++) valid_ff[k] <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_chan.valid;
         for (int k = 1; k < NSTG; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // Stages one and two: the eighteen minor products, then the adjugate.
   for (genvar k = 0; k < 9; k++) begin : g_adj
      always_ff @(posedge clock) begin
         if (en) begin
            prod_ff[2*k]   <= a_in[m3i_pkg::MINOR_IDX[k][0]] * a_in[m3i_pkg::MINOR_IDX[k][1]];
            prod_ff[2*k+1] <= a_in[m3i_pkg::MINOR_IDX[k][2]] * a_in[m3i_pkg::MINOR_IDX[k][3]];
            adj2_ff[k] <= ADJ_W'(prod_ff[2*k]) - ADJ_W'(prod_ff[2*k+1]);
            adj3_ff[k] <= adj2_ff[k];
            adj4_ff[k] <= adj3_ff[k];
            adj5_ff[k] <= adj4_ff[k];
         end
      end
   end

   // Stages three and four: top-row element times cofactor, split in two halves.
   for (genvar j = 0; j < 3; j++) begin : g_term
      always_ff @(posedge clock) begin
         if (en) begin
            a1_ff[j]   <= a_in[j];
            a2_ff[j]   <= a1_ff[j];
            plo_ff[j]  <= a2_ff[j] * $signed({1'b0, adj2_ff[3*j][ELEM_W-1:0]});
            phi_ff[j]  <= a2_ff[j] * $signed(adj2_ff[3*j][ADJ_W-1:ELEM_W]);
            term_ff[j] <= (TERM_W'(phi_ff[j]) <<< ELEM_W) + TERM_W'(plo_ff[j]);
         end
      end
   end

   // Stage five: the determinant.
   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= DET_W'(term_ff[0]) + DET_W'(term_ff[1]) + DET_W'(term_ff[2]);
      end
   end

   // Singular flag runs alongside the dividers.
   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff[0] <= (det_ff == '0);
         for (int k = 1; k < DIV_LAT; k++) sing_ff[k] <= sing_ff[k-1];
      end
   end

   // One divider lane per element: adjugate scaled by 2^(2F) over the determinant.
   for (genvar k = 0; k < 9; k++) begin : g_lane
      m3i_div #(
         .NUM_W (NUM_W),
         .DEN_W (DET_W)
      ) u_div (
         .clock  (clock),
         .en     (en),
         .num_in ($signed({adj5_ff[k], {(2*FRAC_BITS){1'b0}}})),
         .den_in (det_ff),
         .q_out  (q_res[k])
      );

      if (k == 0 || k == 4 || k == 8) begin : g_diag
         assign res_in[k] = sing_ff[DIV_LAT-1] ? ONE : q_res[k];
      end else begin : g_off
         assign res_in[k] = sing_ff[DIV_LAT-1] ? '0 : q_res[k];
      end
   end

   // Output register; it holds while the response transfer is stalled.
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff.out_r0c0 <= res_in[0];
         out_ff.out_r0c1 <= res_in[1];
         out_ff.out_r0c2 <= res_in[2];
         out_ff.out_r1c0 <= res_in[3];
         out_ff.out_r1c1 <= res_in[4];
         out_ff.out_r1c2 <= res_in[5];
         out_ff.out_r2c0 <= res_in[6];
         out_ff.out_r2c1 <= res_in[7];
         out_ff.out_r2c2 <= res_in[8];
         out_ff.singular <= sing_ff[DIV_LAT-1];
      end
   end

   // Partial identity pattern on the output register: r0c0 and r2c2 are one, r0c1 is zero.
   assign sing_ident = out_ff.out_r0c0 == ONE && out_ff.out_r0c1 == '0 &&
                       out_ff.out_r2c2 == ONE;

   // A singular result always carries the identity pattern checked above.
   `M3I_ASSERT_NOW(a_sing_ident, valid_ff[NSTG-1] && out_ff.singular, sing_ident)
   // An accepted request occupies the first stage on the next cycle.
   `M3I_ASSERT_NEXT(a_enter, req_chan.valid && req_chan.ready, valid_ff[0])
   // A stalled pipeline keeps its last stage occupied.
   `M3I_ASSERT_NEXT(a_hold, !en, valid_ff[NSTG-1] && $stable(out_ff))

endmodule
